>>> design/two_axis_homing_centering_controller_defines.svh
// Assertion macros shared by the checker.
`ifndef TWO_AXIS_HOMING_CENTERING_CONTROLLER_DEFINES_SVH
`define TWO_AXIS_HOMING_CENTERING_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define THCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thcc assertion failed");

// next-cycle implication
`define THCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thcc assertion failed");

`endif

>>> design/thcc_pkg.sv
package thcc_pkg;

    localparam int DRIVE_W  = 9;
    localparam int SPEED_W  = 8;
    localparam int TARGET_W = 24;
    localparam int TOL_W    = 12;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;

    // phase codes
    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_HOMING    = 2'd1;
    localparam logic [1:0] PH_CENTERING = 2'd2;
    localparam logic [1:0] PH_DONE      = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOMING_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_FLOOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_CEIL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 3'd4;

    localparam logic [SPEED_W-1:0] HOMING_SPEED_RST = 8'd110;
    localparam logic [SPEED_W-1:0] SPEED_FLOOR_RST  = 8'd115;
    localparam logic [SPEED_W-1:0] SPEED_CEIL_RST   = 8'd255;
    localparam logic [TOL_W-1:0]   TOLERANCE_RST    = 12'd50;

    // error / 25: beyond CLAMP_LIMIT the quotient exceeds any speed ceiling,
    // below it a 13-bit reciprocal multiply is exact
    localparam int GAIN_DIV    = 25;
    localparam int SMALL_W     = 13;
    localparam int CLAMP_LIMIT = GAIN_DIV * 256;
    localparam int RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP = 13'd5243;
    localparam int RECIP_SHIFT = 17;

    typedef struct packed {
        logic                      centered;  // |error| <= tolerance
        logic signed [DRIVE_W-1:0] drive;
    } axis_res_t;

    typedef struct packed {
        logic [TARGET_W-1:0] center_target;
        logic [SPEED_W-1:0]  speed_floor;
        logic [SPEED_W-1:0]  speed_ceil;
        logic [TOL_W-1:0]    tolerance;
    } center_cfg_t;

endpackage

>>> design/two_axis_homing_centering_controller.sv
// Two-axis homing and centering controller. One input beat is one control tick and
// yields exactly one result beat. A beat passes through the input register, one pass of
// per-axis logic and the result register before it can be taken at the output, and a
// new beat is taken every cycle while out_stall stays low. The per-axis error path
// (two wide subtracts in parallel, a 13-bit reciprocal multiply for error/25, clamps)
// sets the cycle time. A start-homing beat (command = 1) restarts homing in any phase.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at the next edge and
// are meant for idle periods.
module two_axis_homing_centering_controller #(
    parameter int ENCODER_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_we,
    input  logic [thcc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [thcc_pkg::CFG_W-1:0]           cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 command,
    input  logic                                 limit_x_closed,
    input  logic                                 limit_y_closed,
    input  logic signed [ENCODER_BITS-1:0]       encoder_x,
    input  logic signed [ENCODER_BITS-1:0]       encoder_y,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [thcc_pkg::DRIVE_W-1:0]  drive_x,
    output logic signed [thcc_pkg::DRIVE_W-1:0]  drive_y,
    output logic                                 clear_encoder_x,
    output logic                                 clear_encoder_y,
    output logic                                 homing_active,
    output logic                                 centering_active,
    output logic                                 calibrate_pulse,
    output logic                                 system_ready
);
    import thcc_pkg::*;

    // configuration
    logic [TARGET_W-1:0] center_target_reg;
    logic [SPEED_W-1:0]  homing_speed_reg;
    logic [SPEED_W-1:0]  speed_floor_reg;
    logic [SPEED_W-1:0]  speed_ceil_reg;
    logic [TOL_W-1:0]    tolerance_reg;

    // input stage
    logic                           s1_valid_reg;
    logic                           s1_command_reg;
    logic                           s1_lim_x_reg;
    logic                           s1_lim_y_reg;
    logic signed [ENCODER_BITS-1:0] s1_enc_x_reg;
    logic signed [ENCODER_BITS-1:0] s1_enc_y_reg;

    // controller state
    logic [1:0]                phase_reg,  phase_next;
    logic                      homed_x_reg, homed_x_next;
    logic                      homed_y_reg, homed_y_next;
    logic signed [DRIVE_W-1:0] held_x_reg, held_x_next;
    logic signed [DRIVE_W-1:0] held_y_reg, held_y_next;
    logic                      ready_reg,  ready_next;
    logic                      clr_x, clr_y, cal;

    // result stage
    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_x_reg;
    logic signed [DRIVE_W-1:0] drive_y_reg;
    logic                      clr_x_reg, clr_y_reg;
    logic                      homing_reg, centering_reg, cal_reg, ready_out_reg;

    logic                      s2_load;
    logic                      s1_fire;
    logic                      in_fire;
    logic signed [DRIVE_W-1:0] homing_drive;
    center_cfg_t               ccfg;
    axis_res_t                 res_x, res_y;

    assign s2_load  = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && s2_load;
    assign in_stall = s1_valid_reg && !s2_load;
    assign in_fire  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_target_reg <= '0;
            homing_speed_reg  <= HOMING_SPEED_RST;
            speed_floor_reg   <= SPEED_FLOOR_RST;
            speed_ceil_reg    <= SPEED_CEIL_RST;
            tolerance_reg     <= TOLERANCE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_TARGET: center_target_reg <= cfg_data[TARGET_W-1:0];
                REG_HOMING_SPEED:  homing_speed_reg  <= cfg_data[SPEED_W-1:0];
                REG_SPEED_FLOOR:   speed_floor_reg   <= cfg_data[SPEED_W-1:0];
                REG_SPEED_CEIL:    speed_ceil_reg    <= cfg_data[SPEED_W-1:0];
                REG_TOLERANCE:     tolerance_reg     <= cfg_data[TOL_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_command_reg <= command;
            s1_lim_x_reg   <= limit_x_closed;
            s1_lim_y_reg   <= limit_y_closed;
            s1_enc_x_reg   <= encoder_x;
            s1_enc_y_reg   <= encoder_y;
        end
    end

    assign ccfg.center_target = center_target_reg;
    assign ccfg.speed_floor   = speed_floor_reg;
    assign ccfg.speed_ceil    = speed_ceil_reg;
    assign ccfg.tolerance     = tolerance_reg;

    thcc_axis #(.ENCODER_BITS(ENCODER_BITS)) u_axis_x (
        .encoder (s1_enc_x_reg),
        .cfg     (ccfg),
        .res     (res_x)
    );

    thcc_axis #(.ENCODER_BITS(ENCODER_BITS)) u_axis_y (
        .encoder (s1_enc_y_reg),
        .cfg     (ccfg),
        .res     (res_y)
    );

    assign homing_drive = -$signed({1'b0, homing_speed_reg});

    always_comb
    begin
        phase_next   = phase_reg;
        homed_x_next = homed_x_reg;
        homed_y_next = homed_y_reg;
        held_x_next  = held_x_reg;
        held_y_next  = held_y_reg;
        ready_next   = ready_reg;
        clr_x        = 1'b0;
        clr_y        = 1'b0;
        cal          = 1'b0;

        if (s1_command_reg)
        begin
            phase_next   = PH_HOMING;
            homed_x_next = s1_lim_x_reg;
            homed_y_next = s1_lim_y_reg;
            clr_x        = s1_lim_x_reg;
            clr_y        = s1_lim_y_reg;
            held_x_next  = s1_lim_x_reg ? '0 : homing_drive;
            held_y_next  = s1_lim_y_reg ? '0 : homing_drive;
        end
        else
        begin
            case (phase_reg)
                PH_HOMING:
                begin
                    if (s1_lim_x_reg || homed_x_reg)
                    begin
                        homed_x_next = 1'b1;
                        clr_x        = 1'b1;
                        held_x_next  = '0;
                    end
                    if (s1_lim_y_reg || homed_y_reg)
                    begin
                        homed_y_next = 1'b1;
                        clr_y        = 1'b1;
                        held_y_next  = '0;
                    end
                    if (homed_x_next && homed_y_next)
                        phase_next = PH_CENTERING;
                end
                PH_CENTERING:
                begin
                    if (res_x.centered && res_y.centered)
                    begin
                        held_x_next = '0;
                        held_y_next = '0;
                        cal         = 1'b1;
                        ready_next  = 1'b1;
                        phase_next  = PH_DONE;
                    end
                    else
                    begin
                        held_x_next = res_x.drive;
                        held_y_next = res_y.drive;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            homed_x_reg <= 1'b0;
            homed_y_reg <= 1'b0;
            held_x_reg  <= '0;
            held_y_reg  <= '0;
            ready_reg   <= 1'b0;
        end
        else if (s1_fire)
        begin
            phase_reg   <= phase_next;
            homed_x_reg <= homed_x_next;
            homed_y_reg <= homed_y_next;
            held_x_reg  <= held_x_next;
            held_y_reg  <= held_y_next;
            ready_reg   <= ready_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_load)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            drive_x_reg   <= held_x_next;
            drive_y_reg   <= held_y_next;
            clr_x_reg     <= clr_x;
            clr_y_reg     <= clr_y;
            homing_reg    <= (phase_next == PH_HOMING);
            centering_reg <= (phase_next == PH_CENTERING);
            cal_reg       <= cal;
            ready_out_reg <= ready_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign drive_x          = drive_x_reg;
    assign drive_y          = drive_y_reg;
    assign clear_encoder_x  = clr_x_reg;
    assign clear_encoder_y  = clr_y_reg;
    assign homing_active    = homing_reg;
    assign centering_active = centering_reg;
    assign calibrate_pulse  = cal_reg;
    assign system_ready     = ready_out_reg;

endmodule

>>> design/thcc_axis.sv
module thcc_axis #(
    parameter int ENCODER_BITS = 32
) (
    input  logic signed [ENCODER_BITS-1:0] encoder,
    input  thcc_pkg::center_cfg_t          cfg,
    output thcc_pkg::axis_res_t            res
);
    import thcc_pkg::*;

    localparam int BASE_W = (ENCODER_BITS > TARGET_W) ? ENCODER_BITS : TARGET_W;
    localparam int ERR_W  = BASE_W + 2;
    localparam int MAG_W  = ERR_W - 1;
    localparam int PROD_W = SMALL_W + RECIP_W;

    logic signed [ERR_W-1:0] tgt_ext;
    logic signed [ERR_W-1:0] enc_ext;
    logic signed [ERR_W-1:0] diff_pos;
    logic signed [ERR_W-1:0] diff_neg;
    logic                    neg;
    logic [MAG_W-1:0]        mag;
    logic                    big;
    logic [PROD_W-1:0]       prod;
    logic [DRIVE_W-1:0]      quot;
    logic [SPEED_W-1:0]      spd;
    logic [DRIVE_W-1:0]      spd_ext;

    assign tgt_ext  = $signed({{(ERR_W-TARGET_W){1'b0}}, cfg.center_target});
    assign enc_ext  = ERR_W'(encoder);
    // both directions in parallel, then pick: no negate after the subtract
    assign diff_pos = tgt_ext - enc_ext;
    assign diff_neg = enc_ext - tgt_ext;
    assign neg      = diff_pos[ERR_W-1];
    assign mag      = neg ? diff_neg[MAG_W-1:0] : diff_pos[MAG_W-1:0];
    assign big      = (mag >= MAG_W'(CLAMP_LIMIT));
    assign prod     = PROD_W'(mag[SMALL_W-1:0]) * PROD_W'(RECIP);

    always_comb
    begin
        if (big)
            quot = DRIVE_W'(256);
        else
            quot = prod[RECIP_SHIFT +: DRIVE_W];

        if (quot > {1'b0, cfg.speed_ceil})
            spd = cfg.speed_ceil;
        else
            spd = quot[SPEED_W-1:0];

        if (spd != '0 && spd < cfg.speed_floor)
            spd = cfg.speed_floor;

        if (mag < MAG_W'(cfg.tolerance))
            spd = '0;
    end

    assign spd_ext      = {1'b0, spd};
    assign res.centered = (mag <= MAG_W'(cfg.tolerance));
    assign res.drive    = neg ? -$signed(spd_ext) : $signed(spd_ext);

endmodule

>>> design/thcc_checker.sv
`include "two_axis_homing_centering_controller_defines.svh"

module thcc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [thcc_pkg::DRIVE_W-1:0] drive_x,
    input logic signed [thcc_pkg::DRIVE_W-1:0] drive_y,
    input logic                                homing_active,
    input logic                                centering_active,
    input logic                                calibrate_pulse,
    input logic                                system_ready
);
    import thcc_pkg::*;

    logic cal_beat;
    logic stopped;
    logic out_held;

    assign cal_beat = out_valid && calibrate_pulse;
    assign stopped  = (drive_x == '0) && (drive_y == '0);
    assign out_held = out_valid && out_stall;

    // completion beat: motors stopped and ready raised
    `THCC_ASSERT_IMPL(a_cal_stops, clk, rst_n, cal_beat, stopped && system_ready)

    // phases are exclusive
    `THCC_ASSERT_IMPL(a_one_phase, clk, rst_n, out_valid, !(homing_active && centering_active))

    // calibration only on leaving centering
    `THCC_ASSERT_IMPL(a_cal_not_active, clk, rst_n, cal_beat, !homing_active && !centering_active)

    // a stalled result beat holds
    `THCC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable({drive_x, system_ready}))

    // input is held off only behind a blocked result
    `THCC_ASSERT_IMPL(a_in_stall, clk, rst_n, in_stall, out_held)

endmodule

bind two_axis_homing_centering_controller thcc_checker u_thcc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .drive_x          (drive_x),
    .drive_y          (drive_y),
    .homing_active    (homing_active),
    .centering_active (centering_active),
    .calibrate_pulse  (calibrate_pulse),
    .system_ready     (system_ready)
);
